// File: rtl/core/yrn_pkg.sv
// ---------------------------------------------------------------------------
// yrn_pkg - shared types and constants for the year to Roman numeral unit
// Symbol table, status codes and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package yrn_pkg;

  localparam int YEAR_W     = 16;
  localparam int ORD_W      = 12;   // ordinals 1..3999 fit in 12 bits
  localparam int CHAR_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int NUM_SYMS   = 13;
  localparam int SYM_W      = 4;

  localparam logic [YEAR_W-1:0] BASE_YEAR_RESET = 16'd1967;
  localparam logic [YEAR_W-1:0] MAX_ORDINAL     = 16'd3999;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EARLY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LARGE = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;
  localparam logic [CHAR_W-1:0] CH_I    = 8'h49;
  localparam logic [CHAR_W-1:0] CH_V    = 8'h56;
  localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_L    = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_C    = 8'h43;
  localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
  localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;

  // controller -> datapath
  typedef struct packed {
    logic load_year;
    logic calc;
    logic emit_err;
    logic emit_char;
  } yrn_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic err;        // ordinal out of range for the held year
    logic out_free;   // output register can take a result this cycle
    logic char_last;  // letter emitted now ends the numeral
  } yrn_stat_t;

  function automatic logic [ORD_W-1:0] sym_value(input logic [SYM_W-1:0] idx);
    logic [ORD_W-1:0] v;
    unique case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  function automatic logic [CHAR_W-1:0] sym_first(input logic [SYM_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      4'd0:    c = CH_M;
      4'd1:    c = CH_C;
      4'd2:    c = CH_D;
      4'd3:    c = CH_C;
      4'd4:    c = CH_C;
      4'd5:    c = CH_X;
      4'd6:    c = CH_L;
      4'd7:    c = CH_X;
      4'd8:    c = CH_X;
      4'd9:    c = CH_I;
      4'd10:   c = CH_V;
      4'd11:   c = CH_I;
      default: c = CH_I;
    endcase
    return c;
  endfunction

  // second letter of a subtractive pair, CH_NONE for single letters
  function automatic logic [CHAR_W-1:0] sym_second(input logic [SYM_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      4'd1:    c = CH_M;
      4'd3:    c = CH_D;
      4'd5:    c = CH_C;
      4'd7:    c = CH_L;
      4'd9:    c = CH_X;
      4'd11:   c = CH_V;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  // largest symbol not above n; symbols run in descending value
  function automatic logic [SYM_W-1:0] pick_sym(input logic [ORD_W-1:0] n);
    logic [SYM_W-1:0] idx;
    idx = SYM_W'(NUM_SYMS - 1);
    for (int i = NUM_SYMS - 1; i >= 0; i--) begin
      if (n >= sym_value(SYM_W'(i))) idx = SYM_W'(i);
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/yrn_ctrl.sv
// ---------------------------------------------------------------------------
// yrn_ctrl - sequencing controller
// Steps one request through ordinal check, then letter or error emission.
// ---------------------------------------------------------------------------
module yrn_ctrl
  import yrn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  yrn_stat_t stat,
  output yrn_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_ERR  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_year = 1'b1;
          state_next    = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = stat.err ? S_ERR : S_EMIT;
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.emit_err = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_char = 1'b1;
          if (stat.char_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/core/yrn_dp.sv
// ---------------------------------------------------------------------------
// yrn_dp - datapath
// Base register, ordinal, greedy symbol pick and the output register.
// ---------------------------------------------------------------------------
module yrn_dp
  import yrn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [YEAR_W-1:0]   cfg_wdata,
  input  logic [YEAR_W-1:0]   year_in,
  input  yrn_cmd_t            cmd,
  output yrn_stat_t           stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   out_char,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_last
);

  logic [YEAR_W-1:0] base_year;
  logic [YEAR_W-1:0] year;
  logic [ORD_W-1:0]  n;
  logic              pending;
  logic [CHAR_W-1:0] second;

  logic [YEAR_W:0]   diff;
  logic              early;
  logic              over_max;
  logic [SYM_W-1:0]  sym;
  logic [ORD_W-1:0]  n_sub;
  logic [CHAR_W-1:0] sym_c2;
  logic [CHAR_W-1:0] char_now;
  logic              last_now;

  assign diff     = {1'b0, year} - {1'b0, base_year};
  assign early    = diff[YEAR_W];
  assign over_max = !early && (diff[YEAR_W-1:0] >= MAX_ORDINAL);

  assign sym    = pick_sym(n);
  assign n_sub  = n - sym_value(sym);
  assign sym_c2 = sym_second(sym);

  always_comb begin
    if (pending) begin
      char_now = second;
      last_now = (n == '0);
    end else begin
      char_now = sym_first(sym);
      last_now = (sym_c2 == CH_NONE) && (n_sub == '0);
    end
  end

  assign stat.err       = early || over_max;
  assign stat.out_free  = !out_valid || out_ready;
  assign stat.char_last = last_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_year <= BASE_YEAR_RESET;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) base_year <= cfg_wdata;
      if (cmd.calc) pending <= 1'b0;
      if (cmd.emit_char) begin
        if (pending) begin
          pending <= 1'b0;
        end else if (sym_c2 != CH_NONE) begin
          pending <= 1'b1;
        end
      end
      if (cmd.emit_char || cmd.emit_err) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_year) year <= year_in;
    if (cmd.calc) n <= diff[ORD_W-1:0] + ORD_W'(1);
    if (cmd.emit_char && !pending) begin
      n      <= n_sub;
      second <= sym_c2;
    end
    if (cmd.emit_char) begin
      out_char   <= char_now;
      out_status <= ST_OK;
      out_last   <= last_now;
    end else if (cmd.emit_err) begin
      out_char   <= CH_NONE;
      out_status <= early ? ST_EARLY : ST_LARGE;
      out_last   <= 1'b1;
    end
  end

endmodule

// File: rtl/core/year_to_roman_numeral_chars_unit.sv
// ---------------------------------------------------------------------------
// year_to_roman_numeral_chars_unit - year to Roman numeral letter stream
// Forms ordinal = year - base_year + 1 and streams its numeral letters.
// ---------------------------------------------------------------------------
//  channel   | dir | tdata        | tuser       | tlast
//  s_axis    | in  | [15:0] year  | -           | -
//  m_axis    | out | [7:0] char   | [1:0] status| last letter / error
//  cfg       | in  | cfg_wdata [15:0] base_year, written when cfg_we
//
//  A request is accepted, then the ordinal subtract and range check run, then
//  its letters follow (1 to 15 per numeral), or the error result does. Letters
//  come one a cycle from the greedy symbol pick and the single output
//  register while the output takes them. Output stalls hold the sequence.
//  Reset is synchronous, restores base_year to 1967 and empties the output.
// ---------------------------------------------------------------------------
module year_to_roman_numeral_chars_unit
  import yrn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [YEAR_W-1:0]   cfg_wdata,      // base_year
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [YEAR_W-1:0]   s_axis_tdata,   // [15:0] year
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [CHAR_W-1:0]   m_axis_tdata,   // [7:0] char_code
  output logic [STATUS_W-1:0] m_axis_tuser,   // [1:0] status
  output logic                m_axis_tlast
);

  yrn_cmd_t  cmd;
  yrn_stat_t stat;

  yrn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  yrn_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .year_in    (s_axis_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_char   (m_axis_tdata),
    .out_status (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again while a request is in progress");

  a_err_result_form: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |->
      (m_axis_tdata == CH_NONE) && m_axis_tlast &&
      ((m_axis_tuser == ST_EARLY) || (m_axis_tuser == ST_LARGE)))
    else $error("malformed error result");

  a_letter_legal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_OK) |->
      (m_axis_tdata == CH_I) || (m_axis_tdata == CH_V) || (m_axis_tdata == CH_X) ||
      (m_axis_tdata == CH_L) || (m_axis_tdata == CH_C) || (m_axis_tdata == CH_D) ||
      (m_axis_tdata == CH_M))
    else $error("letter outside the numeral alphabet");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output result changed while stalled");

endmodule

// File: test/roman_letter_checker.sv
// ---------------------------------------------------------------------------
// roman_letter_checker - predictor and scoreboard for the numeral letter stream
// Tracks base_year, forecasts the letters of every accepted year request and
// compares each accepted output letter with the oldest forecast.
// ---------------------------------------------------------------------------
module roman_letter_checker
  import yrn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [YEAR_W-1:0]   cfg_wdata,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [YEAR_W-1:0]   s_axis_tdata,   // [15:0] year
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [CHAR_W-1:0]   m_axis_tdata,   // [7:0] char_code
  input  logic [STATUS_W-1:0] m_axis_tuser,   // [1:0] status
  input  logic                m_axis_tlast,
  output int                  expected_count,
  output int                  mismatch_count
);

  typedef struct packed {
    logic [CHAR_W-1:0]   code;
    logic [STATUS_W-1:0] status;
    logic                last;
  } letter_t;

  // greedy table, largest value first
  localparam logic [0:12][11:0] SYM_VALUE = {
    12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
    12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
  };
  localparam logic [0:12][CHAR_W-1:0] SYM_HEAD = {
    CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
  };
  localparam logic [0:12][CHAR_W-1:0] SYM_TAIL = {
    CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C, CH_NONE, CH_L, CH_NONE,
    CH_X, CH_NONE, CH_V, CH_NONE
  };

  letter_t           expected_letters[$];
  logic [YEAR_W-1:0] base_year;

  function automatic letter_t make_letter(input logic [CHAR_W-1:0] code,
                                          input logic [STATUS_W-1:0] status,
                                          input logic last);
    letter_t l;
    l.code   = code;
    l.status = status;
    l.last   = last;
    return l;
  endfunction

  function automatic void forecast_numeral(input logic [YEAR_W-1:0] yr);
    int      n;
    letter_t tail;
    if (yr < base_year) begin
      expected_letters.push_back(make_letter(CH_NONE, ST_EARLY, 1'b1));
      return;
    end
    n = int'(yr) - int'(base_year) + 1;
    if (n > int'(MAX_ORDINAL)) begin
      expected_letters.push_back(make_letter(CH_NONE, ST_LARGE, 1'b1));
      return;
    end
    for (int s = 0; s < NUM_SYMS; s++) begin
      while (n >= int'(SYM_VALUE[s])) begin
        n -= int'(SYM_VALUE[s]);
        expected_letters.push_back(make_letter(SYM_HEAD[s], ST_OK, 1'b0));
        if (SYM_TAIL[s] != CH_NONE)
          expected_letters.push_back(make_letter(SYM_TAIL[s], ST_OK, 1'b0));
      end
    end
    // mark the final letter of the numeral
    tail = expected_letters.pop_back();
    tail.last = 1'b1;
    expected_letters.push_back(tail);
  endfunction

  initial begin
    expected_count = 0;
    mismatch_count = 0;
  end

  always @(posedge clk) begin
    letter_t want;
    if (rst) begin
      base_year = BASE_YEAR_RESET;
    end else begin
      if (s_axis_tvalid && s_axis_tready) forecast_numeral(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_letters.size() == 0) begin
          $error("unexpected letter: char_code %0h status %0d last %0b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          mismatch_count++;
        end else begin
          want = expected_letters.pop_front();
          if (m_axis_tdata !== want.code) begin
            $error("char_code: expected %0h, actual %0h", want.code, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
            mismatch_count++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) base_year = cfg_wdata;
      expected_count = expected_letters.size();
    end
  end

endmodule

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench - year to Roman numeral letter stream, top of the test
// Drives year requests and base_year writes with random gaps and stalls;
// a checker beside the unit predicts and compares every output letter.
// ---------------------------------------------------------------------------
module testbench;
  import yrn_pkg::*;

  localparam int  HOLD_CYCLES  = 200;
  localparam int  DRAIN_CYCLES = 20;
  localparam int  PHASE_ITEMS  = 75;

  // ordinals hit at the reset base: every symbol plus the longest and largest
  localparam logic [0:14][11:0] EDGE_ORDINALS = {
    12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd50, 12'd90, 12'd100,
    12'd400, 12'd500, 12'd900, 12'd1000, 12'd3888, 12'd3999
  };

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [YEAR_W-1:0]   cfg_wdata;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [YEAR_W-1:0]   s_axis_tdata;   // [15:0] year
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [CHAR_W-1:0]   m_axis_tdata;   // [7:0] char_code
  logic [STATUS_W-1:0] m_axis_tuser;   // [1:0] status
  logic                m_axis_tlast;

  int expected_count;
  int mismatch_count;
  bit tx_eager;
  bit rx_eager;
  bit hold_req;

  year_to_roman_numeral_chars_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  roman_letter_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .expected_count (expected_count),
    .mismatch_count (mismatch_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #(12 * 400000);
    $display("FAIL year_to_roman_numeral_chars_unit");
    $finish;
  end

  // receiver: random stall before each letter unless rx_eager, one long hold-off on request
  initial begin
    int gap;
    m_axis_tready <= 1'b0;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = rx_eager ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // keep tvalid high across back-to-back requests; drop it only for a gap
  task automatic send_year(input logic [YEAR_W-1:0] yr);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= yr;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (expected_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_base(input logic [YEAR_W-1:0] base);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    cfg_wdata <= base;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly valid ordinals, with early, too large and raw years mixed in
  function automatic logic [YEAR_W-1:0] pick_year(input int base);
    int r;
    int yr;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      yr = base + ((r < 10) ? $urandom_range(3800, 3999) : $urandom_range(1, 3999)) - 1;
      if (yr > 65535) yr = $urandom_range(base, 65535);
    end else if (r < 80 && base > 0) begin
      yr = $urandom_range(0, base - 1);
    end else if (r < 90 && base + 3999 <= 65535) begin
      yr = $urandom_range(base + 3999, 65535);
    end else begin
      yr = $urandom_range(0, 65535);
    end
    return YEAR_W'(yr);
  endfunction

  initial begin
    int base;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    tx_eager = 1'b0;
    rx_eager = 1'b0;
    hold_req = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 15; i++)
      send_year(YEAR_W'(int'(BASE_YEAR_RESET) + int'(EDGE_ORDINALS[i]) - 1));
    send_year(BASE_YEAR_RESET - 16'd1);
    send_year(16'd0);
    send_year(YEAR_W'(int'(BASE_YEAR_RESET) + 3999));
    send_year(16'hFFFF);

    load_base(16'd0);
    send_year(16'd0);
    send_year(16'd3998);
    send_year(16'd3999);

    load_base(16'hFFFF);
    send_year(16'hFFFF);
    send_year(16'd0);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       base = $urandom_range(0, 65535);
        1:       base = int'(BASE_YEAR_RESET);
        2:       base = 65535;
        3:       base = $urandom_range(0, 4000);
        4:       base = 0;
        default: base = $urandom_range(60000, 65535);
      endcase
      load_base(YEAR_W'(base));
      tx_eager = (p == 1) || (p == 4);
      rx_eager = (p == 3);
      // back-to-back requests against a stalled output fill the unit
      if (p == 1) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_year(pick_year(base));
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();
    if (mismatch_count == 0 && expected_count == 0)
      $display("PASS year_to_roman_numeral_chars_unit");
    else
      $display("FAIL year_to_roman_numeral_chars_unit");
    $finish;
  end

endmodule
